>>> src/regret_threshold_projection_defines.svh
// assertion macros for the regret threshold projection block
`ifndef REGRET_THRESHOLD_PROJECTION_DEFINES_SVH
`define REGRET_THRESHOLD_PROJECTION_DEFINES_SVH

// same-cycle implication
`define RTP_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("rtp check failed");

// next-cycle implication
`define RTP_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("rtp check failed");

`endif

>>> src/rtp_pkg.sv
// package of the regret threshold projection block
`default_nettype none
package rtp_pkg;
  localparam int MAX_ACTIONS_DEF = 16;
  localparam int VAL_W = 32;
  localparam int PROB_W = 17;
  localparam int REACH_W = 32;
  localparam int IDX_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [31:0] ALPHA_RESET = 32'd65536;
  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST = 1'b1;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    logic [31:0] r;
    r = x[31:0];
    if (!x[63] && (x[62:31] != 32'd0)) r = 32'h7fff_ffff;
    if (x[63] && (x[62:31] != 32'hffff_ffff)) r = 32'h8000_0000;
    return r;
  endfunction
endpackage
`default_nettype wire

>>> src/rtp_in_if.sv
// input channel of the regret threshold projection block
`default_nettype none
interface rtp_in_if;
  logic valid;
  logic ready;
  logic signed [rtp_pkg::VAL_W-1:0] action_value;
  logic [rtp_pkg::PROB_W-1:0] policy_prob;
  logic [rtp_pkg::REACH_W-1:0] opp_reach;
  logic last_action;
  modport source (output valid, action_value, policy_prob, opp_reach, last_action,
                  input ready);
  modport sink (input valid, action_value, policy_prob, opp_reach, last_action,
                output ready);
endinterface
`default_nettype wire

>>> src/rtp_out_if.sv
// result channel of the regret threshold projection block
`default_nettype none
interface rtp_out_if;
  logic valid;
  logic ready;
  logic [rtp_pkg::IDX_W-1:0] act_pos;
  logic signed [rtp_pkg::VAL_W-1:0] shifted_value;
  logic signed [rtp_pkg::VAL_W-1:0] root_value;
  logic overflow;
  logic last_result;
  modport source (output valid, act_pos, shifted_value, root_value, overflow,
                  last_result, input ready);
  modport sink (input valid, act_pos, shifted_value, root_value, overflow,
                last_result, output ready);
endinterface
`default_nettype wire

>>> src/regret_threshold_projection.sv
// top level of the regret threshold projection block
//
//   channel   | dir | handshake          | payload
//   in_item   | in  | valid/ready        | action_value, policy_prob, opp_reach, last_action
//   out_item  | out | valid/ready        | act_pos, shifted_value, root_value, overflow,
//             |     |                    | last_result
//   cfg       | in  | cfg_we             | cfg_index, cfg_data
//
// loading accepts one item per cycle; the item marked last starts the run
// each action's offset is worked out in the shared multiply, divide and sqrt unit
// sorting and the tail search follow, then the root
// each result is read from the store before it is offered; input is not ready from the last item until the final result
// synchronous reset; no clearing pass, stores are written before they are read
`default_nettype none
module regret_threshold_projection #(
  parameter int MAX_ACTIONS = rtp_pkg::MAX_ACTIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rtp_in_if.sink    in_item,
  rtp_out_if.source out_item,
  input  wire logic cfg_we,
  input  wire logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rtp_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int AW = $clog2(MAX_ACTIONS);
  localparam int CW = $clog2(MAX_ACTIONS + 1);
  localparam int NW = 33 + $clog2(MAX_ACTIONS);

  typedef enum logic [4:0] {
    ST_LOAD, ST_THR, ST_SH_RD, ST_SH_DAT, ST_SH_DV, ST_SH_SQ, ST_SH_WR,
    ST_SRT_X, ST_SRT_XD, ST_SRT_CMP, ST_SRT_PUT,
    ST_TL_I, ST_TL_SI, ST_TL_SQ, ST_TL_ACC, ST_TL_CHK,
    ST_RT_M2, ST_RT_SQ, ST_RT_DIV, ST_RT_FIN,
    ST_MUL, ST_DIV, ST_SQRT, ST_OUT_RD, ST_OUT_V
  } state_t;

  state_t state_r, ret_r;
  logic [31:0] alpha_r;
  logic first_r;
  logic [CW-1:0] count_r, n_r, k_r, m_r, i_r, j_r;
  logic [NW-1:0] norm_r;
  logic dropped_r;
  logic [31:0] reach_r;
  logic [63:0] thr_r;
  logic [31:0] val_r, x_r, si_r, d_r, root_r;
  logic [63:0] tail_r, sd_r, sq_r;
  logic [63:0] ma_r, mb_r;
  logic [127:0] acc_r;
  logic [1:0] mstep_r;
  logic [63:0] dnum_r, dquo_r;
  logic [NW-1:0] drem_r, dv_r;
  logic [127:0] sx_r;
  logic [65:0] srem_r;
  logic [63:0] sroot_r;
  logic [5:0] cnt_r;

  logic [31:0] value_mem [MAX_ACTIONS];
  logic [rtp_pkg::PROB_W-1:0] policy_mem [MAX_ACTIONS];
  logic [31:0] sorted_mem [MAX_ACTIONS];
  logic [31:0] vrd_r, srd_r;
  logic [rtp_pkg::PROB_W-1:0] prd_r;

  logic in_acc;
  logic [rtp_pkg::PROB_W-1:0] p_clamp;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [127:0] acc_add;
  logic [CW:0] k_inc, i_inc, j_inc;
  logic [CW-1:0] a_cnt;
  logic [AW-1:0] sa;
  logic vwe, swe;
  logic [AW-1:0] vwa, swa;
  logic [31:0] vwd, swd;
  logic [31:0] d_cur;
  logic [64:0] tail_sum;
  logic [NW:0] drem_sh;
  logic div_ge;
  logic [67:0] srem_sh, strial;
  logic sq_ge;
  logic [63:0] shift_sum, root_diff;
  logic [7:0] k_ext;

  assign in_acc = in_item.valid && in_item.ready;
  assign p_clamp = (in_item.policy_prob > rtp_pkg::PROB_ONE) ? rtp_pkg::PROB_ONE
                                                             : in_item.policy_prob;
  assign k_inc = {1'b0, k_r} + 1'b1;
  assign i_inc = {1'b0, i_r} + 1'b1;
  assign j_inc = {1'b0, j_r} + 1'b1;
  assign a_cnt = n_r - i_r;
  assign d_cur = srd_r - si_r;
  assign tail_sum = {1'b0, tail_r} + {1'b0, sq_r};
  assign drem_sh = {drem_r, dnum_r[63]};
  assign div_ge = drem_sh >= {1'b0, dv_r};
  assign srem_sh = {srem_r, sx_r[127:126]};
  assign strial = {2'b00, sroot_r, 2'b01};
  assign sq_ge = srem_sh >= strial;
  assign shift_sum = {{32{val_r[31]}}, val_r} + sroot_r;
  assign root_diff = {{32{si_r[31]}}, si_r} - dquo_r;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      ST_LOAD: begin
        mul_a = 32'(p_clamp);
        mul_b = 32'(p_clamp);
      end
      ST_THR: begin
        mul_a = alpha_r;
        mul_b = reach_r;
      end
      ST_SH_DAT: begin
        mul_a = 32'(prd_r);
        mul_b = 32'(prd_r);
      end
      ST_TL_SQ: begin
        mul_a = d_cur;
        mul_b = d_cur;
      end
      ST_MUL: begin
        mul_a = mstep_r[1] ? ma_r[63:32] : ma_r[31:0];
        mul_b = mstep_r[0] ? mb_r[63:32] : mb_r[31:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (mstep_r)
      2'd0: acc_add = {64'd0, mul_p};
      2'd1, 2'd2: acc_add = {32'd0, mul_p, 32'd0};
      default: acc_add = {mul_p, 64'd0};
    endcase
  end

  always_comb begin
    vwe = 1'b0;
    vwa = k_r[AW-1:0];
    vwd = rtp_pkg::sat32(shift_sum);
    swe = 1'b0;
    swa = m_r[AW-1:0];
    swd = x_r;
    sa = i_r[AW-1:0];
    unique case (state_r)
      ST_LOAD: begin
        vwe = in_acc && (count_r < CW'(MAX_ACTIONS));
        vwa = count_r[AW-1:0];
        vwd = in_item.action_value;
      end
      ST_SH_WR: vwe = 1'b1;
      ST_SRT_XD: begin
        swe = (k_r == '0);
        swa = '0;
        swd = vrd_r;
        sa = AW'(k_r - 1'b1);
      end
      ST_SRT_CMP: begin
        swe = 1'b1;
        swd = ($signed(srd_r) > $signed(x_r)) ? srd_r : x_r;
        sa = AW'(m_r - 2'd2);
      end
      ST_SRT_PUT: begin
        swe = 1'b1;
        swa = '0;
      end
      ST_TL_ACC: sa = AW'(j_inc);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) value_mem[vwa] <= vwd;
    if (vwe && (state_r == ST_LOAD)) policy_mem[vwa] <= p_clamp;
    if (swe) sorted_mem[swa] <= swd;
    vrd_r <= value_mem[k_r[AW-1:0]];
    prd_r <= policy_mem[k_r[AW-1:0]];
    srd_r <= sorted_mem[sa];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ret_r <= ST_LOAD;
      alpha_r <= rtp_pkg::ALPHA_RESET;
      first_r <= 1'b1;
      count_r <= '0;
      norm_r <= '0;
      dropped_r <= 1'b0;
      reach_r <= '0;
      k_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rtp_pkg::REG_ALPHA) alpha_r <= cfg_data;
        if (cfg_index == rtp_pkg::REG_FIRST) first_r <= cfg_data[0];
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (count_r < CW'(MAX_ACTIONS)) begin
              count_r <= count_r + 1'b1;
              norm_r <= norm_r + NW'(mul_p);
            end else begin
              dropped_r <= 1'b1;
            end
            if (in_item.last_action) begin
              reach_r <= in_item.opp_reach;
              state_r <= ST_THR;
            end
          end
        end
        ST_THR: begin
          thr_r <= mul_p;
          n_r <= count_r;
          k_r <= '0;
          state_r <= ST_SH_RD;
        end
        ST_SH_RD: state_r <= ST_SH_DAT;
        ST_SH_DAT: begin
          val_r <= vrd_r;
          if (!first_r && (norm_r != '0)) begin
            ma_r <= mul_p;
            mb_r <= thr_r;
            acc_r <= '0;
            mstep_r <= 2'd0;
            ret_r <= ST_SH_DV;
            state_r <= ST_MUL;
          end else begin
            sroot_r <= '0;
            state_r <= ST_SH_WR;
          end
        end
        ST_SH_DV: begin
          dnum_r <= acc_r[63:0];
          drem_r <= NW'(acc_r[127:64]);
          dv_r <= norm_r;
          cnt_r <= '0;
          ret_r <= ST_SH_SQ;
          state_r <= ST_DIV;
        end
        ST_SH_SQ: begin
          sx_r <= {64'd0, dquo_r};
          srem_r <= '0;
          sroot_r <= '0;
          cnt_r <= '0;
          ret_r <= ST_SH_WR;
          state_r <= ST_SQRT;
        end
        ST_SH_WR: begin
          if (k_inc < {1'b0, n_r}) begin
            k_r <= CW'(k_inc);
            state_r <= ST_SH_RD;
          end else begin
            k_r <= '0;
            state_r <= ST_SRT_X;
          end
        end
        ST_SRT_X: state_r <= ST_SRT_XD;
        ST_SRT_XD: begin
          x_r <= vrd_r;
          m_r <= k_r;
          if (k_r != '0) begin
            state_r <= ST_SRT_CMP;
          end else if (k_inc < {1'b0, n_r}) begin
            k_r <= CW'(k_inc);
            state_r <= ST_SRT_X;
          end else begin
            i_r <= '0;
            state_r <= ST_TL_I;
          end
        end
        ST_SRT_CMP: begin
          if ($signed(srd_r) > $signed(x_r)) begin
            m_r <= m_r - 1'b1;
            if (m_r == CW'(1)) state_r <= ST_SRT_PUT;
          end else if (k_inc < {1'b0, n_r}) begin
            k_r <= CW'(k_inc);
            state_r <= ST_SRT_X;
          end else begin
            i_r <= '0;
            state_r <= ST_TL_I;
          end
        end
        ST_SRT_PUT: begin
          if (k_inc < {1'b0, n_r}) begin
            k_r <= CW'(k_inc);
            state_r <= ST_SRT_X;
          end else begin
            i_r <= '0;
            state_r <= ST_TL_I;
          end
        end
        ST_TL_I: state_r <= ST_TL_SI;
        ST_TL_SI: begin
          si_r <= srd_r;
          j_r <= i_r;
          tail_r <= '0;
          sd_r <= '0;
          state_r <= ST_TL_SQ;
        end
        ST_TL_SQ: begin
          d_r <= d_cur;
          sq_r <= mul_p;
          state_r <= ST_TL_ACC;
        end
        ST_TL_ACC: begin
          tail_r <= tail_sum[64] ? 64'hffff_ffff_ffff_ffff : tail_sum[63:0];
          sd_r <= sd_r + {32'd0, d_r};
          if (j_inc < {1'b0, n_r}) begin
            j_r <= CW'(j_inc);
            state_r <= ST_TL_SQ;
          end else begin
            state_r <= ST_TL_CHK;
          end
        end
        ST_TL_CHK: begin
          if (tail_r < thr_r) begin
            ma_r <= sd_r;
            mb_r <= sd_r;
            acc_r <= '0;
            mstep_r <= 2'd0;
            ret_r <= ST_RT_M2;
            state_r <= ST_MUL;
          end else if (i_inc < {1'b0, n_r}) begin
            i_r <= CW'(i_inc);
            state_r <= ST_TL_I;
          end else begin
            root_r <= '0;
            k_r <= '0;
            state_r <= ST_OUT_RD;
          end
        end
        ST_RT_M2: begin
          ma_r <= thr_r - tail_r;
          mb_r <= 64'(a_cnt);
          mstep_r <= 2'd0;
          ret_r <= ST_RT_SQ;
          state_r <= ST_MUL;
        end
        ST_RT_SQ: begin
          sx_r <= acc_r;
          srem_r <= '0;
          sroot_r <= '0;
          cnt_r <= '0;
          ret_r <= ST_RT_DIV;
          state_r <= ST_SQRT;
        end
        ST_RT_DIV: begin
          dnum_r <= sroot_r - sd_r;
          drem_r <= '0;
          dv_r <= NW'(a_cnt);
          cnt_r <= '0;
          ret_r <= ST_RT_FIN;
          state_r <= ST_DIV;
        end
        ST_RT_FIN: begin
          root_r <= rtp_pkg::sat32(root_diff);
          k_r <= '0;
          state_r <= ST_OUT_RD;
        end
        ST_MUL: begin
          acc_r <= acc_r + acc_add;
          mstep_r <= mstep_r + 1'b1;
          if (mstep_r == 2'd3) state_r <= ret_r;
        end
        ST_DIV: begin
          drem_r <= div_ge ? NW'(drem_sh - {1'b0, dv_r}) : NW'(drem_sh);
          dquo_r <= {dquo_r[62:0], div_ge};
          dnum_r <= {dnum_r[62:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) state_r <= ret_r;
        end
        ST_SQRT: begin
          srem_r <= sq_ge ? 66'(srem_sh - strial) : 66'(srem_sh);
          sroot_r <= {sroot_r[62:0], sq_ge};
          sx_r <= {sx_r[125:0], 2'b00};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) state_r <= ret_r;
        end
        ST_OUT_RD: state_r <= ST_OUT_V;
        ST_OUT_V: begin
          if (out_item.ready) begin
            if (k_inc == {1'b0, n_r}) begin
              count_r <= '0;
              norm_r <= '0;
              dropped_r <= 1'b0;
              k_r <= '0;
              state_r <= ST_LOAD;
            end else begin
              k_r <= CW'(k_inc);
              state_r <= ST_OUT_RD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign k_ext = 8'(k_r);
  assign in_item.ready = (state_r == ST_LOAD);
  assign out_item.valid = (state_r == ST_OUT_V);
  assign out_item.act_pos = k_ext[rtp_pkg::IDX_W-1:0];
  assign out_item.shifted_value = vrd_r;
  assign out_item.root_value = root_r;
  assign out_item.overflow = dropped_r;
  assign out_item.last_result = (k_inc == {1'b0, n_r});
endmodule
`default_nettype wire

>>> src/rtp_checker.sv
// port checker of the regret threshold projection block and its bind
`default_nettype none
`include "regret_threshold_projection_defines.svh"
module rtp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic [31:0] out_shifted,
  input wire logic [31:0] out_root
);
  `RTP_ASSERT_NOW(a_no_load_while_out, out_valid, !in_ready)
  `RTP_ASSERT_NEXT(a_mid_set_ready, in_valid && in_ready && !in_last, in_ready)
  `RTP_ASSERT_NEXT(a_ready_after_run, out_valid && out_ready && out_last, in_ready)
  `RTP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_shifted) && $stable(out_root))
endmodule

bind regret_threshold_projection rtp_checker u_rtp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_item.valid),
  .in_ready(in_item.ready),
  .in_last(in_item.last_action),
  .out_valid(out_item.valid),
  .out_ready(out_item.ready),
  .out_last(out_item.last_result),
  .out_shifted(out_item.shifted_value),
  .out_root(out_item.root_value)
);
`default_nettype wire

>>> test/tb_regret_threshold_projection.sv
// testbench for the regret threshold projection block: directed and random item sets against a predictor
`timescale 1ns / 100ps

typedef struct {
  logic [3:0]  act_pos;
  logic [31:0] shifted_value;
  logic [31:0] root_value;
  logic        overflow;
  logic        last_result;
} rtp_result_t;

class rtp_scoreboard;
  bit [31:0]        alpha = rtp_pkg::ALPHA_RESET;
  bit               first_iter = 1'b1;
  bit signed [31:0] vals[16];
  bit [16:0]        probs[16];
  int unsigned      count;
  bit [63:0]        norm;
  bit               dropped;
  rtp_result_t      expected_q[$];
  int               errors;
  int               results_seen;
  int               sets_done;
  int               overflow_sets;
  int               rooted_sets;

  function bit [63:0] isqrt128(bit [127:0] x);
    bit [63:0] r;
    bit [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (({64'd0, c} * {64'd0, c}) <= x) r = c;
    end
    return r;
  endfunction

  function longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function void note_item(bit signed [31:0] v, bit [16:0] p_raw, bit [31:0] reach, bit lst);
    bit [16:0]   p;
    bit [63:0]   thr;
    bit [127:0]  num;
    bit [127:0]  quo;
    bit [63:0]   tail;
    bit [64:0]   tsum;
    bit [63:0]   sd;
    bit [63:0]   d;
    bit [63:0]   a;
    bit [63:0]   r;
    bit [63:0]   off;
    bit [127:0]  disc;
    longint      shifted[16];
    longint      srt[16];
    longint      root;
    longint      x;
    int          n;
    int          m;
    rtp_result_t res;
    p = (p_raw > rtp_pkg::PROB_ONE) ? rtp_pkg::PROB_ONE : p_raw;
    if (count < 16) begin
      vals[count] = v;
      probs[count] = p;
      norm += 64'(p) * 64'(p);
      count++;
    end else begin
      dropped = 1'b1;
    end
    if (!lst) return;
    thr = 64'(alpha) * 64'(reach);
    n = count;
    root = 0;
    for (int k = 0; k < n; k++) begin
      x = longint'(vals[k]);
      if (!first_iter && norm != 0) begin
        num = 128'(64'(probs[k]) * 64'(probs[k])) * 128'(thr);
        quo = num / 128'(norm);
        x += longint'(isqrt128(quo));
      end
      shifted[k] = clip32(x);
    end
    for (int k = 0; k < n; k++) begin
      m = k;
      while (m > 0 && srt[m-1] > shifted[k]) begin
        srt[m] = srt[m-1];
        m--;
      end
      srt[m] = shifted[k];
    end
    for (int i = 0; i < n; i++) begin
      tail = '0;
      sd = '0;
      for (int j = i; j < n; j++) begin
        d = 64'(srt[j] - srt[i]);
        tsum = 65'(tail) + 65'(d * d);
        tail = tsum[64] ? '1 : tsum[63:0];
        sd += d;
      end
      if (tail < thr) begin
        a = 64'(n - i);
        disc = 128'(sd) * 128'(sd) + 128'(thr - tail) * 128'(a);
        r = isqrt128(disc);
        off = (r - sd) / a;
        root = clip32(srt[i] - longint'(off));
        rooted_sets++;
        break;
      end
    end
    for (int k = 0; k < n; k++) begin
      res.act_pos = 4'(k);
      res.shifted_value = shifted[k][31:0];
      res.root_value = root[31:0];
      res.overflow = dropped;
      res.last_result = (k == n - 1);
      expected_q.insert(expected_q.size(), res);
    end
    sets_done++;
    if (dropped) overflow_sets++;
    count = 0;
    norm = '0;
    dropped = 1'b0;
  endfunction

  function void check_result(rtp_result_t got);
    rtp_result_t exp_r;
    results_seen++;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t unexpected result: expected none actual idx %0d value %h", $time,
               got.act_pos, got.shifted_value);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.act_pos !== exp_r.act_pos) begin
      errors++;
      $display("%0t act_pos: expected %0d actual %0d", $time, exp_r.act_pos,
               got.act_pos);
    end
    if (got.shifted_value !== exp_r.shifted_value) begin
      errors++;
      $display("%0t shifted_value: expected %h actual %h", $time, exp_r.shifted_value,
               got.shifted_value);
    end
    if (got.root_value !== exp_r.root_value) begin
      errors++;
      $display("%0t root_value: expected %h actual %h", $time, exp_r.root_value,
               got.root_value);
    end
    if (got.overflow !== exp_r.overflow) begin
      errors++;
      $display("%0t overflow: expected %b actual %b", $time, exp_r.overflow, got.overflow);
    end
    if (got.last_result !== exp_r.last_result) begin
      errors++;
      $display("%0t last_result: expected %b actual %b", $time, exp_r.last_result,
               got.last_result);
    end
  endfunction
endclass

module tb_regret_threshold_projection;
  localparam int CYCLE_LIMIT = 800000;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  cfg_we;
  logic [rtp_pkg::CFG_IDX_W-1:0]         cfg_index;
  logic [rtp_pkg::CFG_DATA_W-1:0]        cfg_data;

  rtp_in_if  in_if();
  rtp_out_if out_if();

  regret_threshold_projection dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_item(in_if),
    .out_item(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rtp_scoreboard sb = new();
  int     idle_pct = 32;
  int     hold_left = 0;
  int     cycles = 0;
  int     items_sent = 0;
  rtp_result_t got;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check accepted items, then pick ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got.act_pos = out_if.act_pos;
      got.shifted_value = out_if.shifted_value;
      got.root_value = out_if.root_value;
      got.overflow = out_if.overflow;
      got.last_result = out_if.last_result;
      sb.check_result(got);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  task automatic send_item(logic [31:0] v, logic [16:0] p, logic [31:0] reach, logic lst);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action_value <= v;
    in_if.policy_prob <= p;
    in_if.opp_reach <= reach;
    in_if.last_action <= lst;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(v, p, reach, lst);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [rtp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == rtp_pkg::REG_ALPHA) sb.alpha = data;
    else sb.first_iter = data[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value(int spread);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fff_ffff - $urandom_range(0, 255);
      2: return 32'h8000_0000 + $urandom_range(0, 255);
      default: return 32'($urandom_range(0, 2 * spread) - spread);
    endcase
  endfunction

  function automatic logic [16:0] pick_prob();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return rtp_pkg::PROB_ONE;
      2: return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] pick_reach();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  task automatic send_set(int n);
    int spread;
    spread = 1 << $urandom_range(4, 20);
    for (int k = 0; k < n; k++)
      send_item(pick_value(spread), pick_prob(), pick_reach(), k == n - 1);
  endtask

  initial begin
    int n;
    in_if.valid <= 1'b0;
    in_if.action_value <= '0;
    in_if.policy_prob <= '0;
    in_if.opp_reach <= '0;
    in_if.last_action <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= rtp_pkg::REG_ALPHA;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes with reset settings, probability clamp
    send_item(32'h7fff_ffff, 17'h1ffff, 32'hffff_ffff, 1'b1);
    send_item(32'h8000_0000, 17'd0, 32'd0, 1'b0);
    send_item(32'h8000_0000, 17'd65537, 32'd0, 1'b1);
    // policy offset with largest threshold
    write_reg(rtp_pkg::REG_FIRST, 32'd0);
    write_reg(rtp_pkg::REG_ALPHA, 32'hffff_ffff);
    send_item(32'h7fff_0000, rtp_pkg::PROB_ONE, 32'd0, 1'b0);
    send_item(32'h0000_0000, 17'd1, 32'd0, 1'b0);
    send_item(32'hffff_0000, 17'h1ffff, 32'hffff_ffff, 1'b1);
    // zero norm
    send_item(32'h0001_0000, 17'd0, 32'd0, 1'b0);
    send_item(32'h0001_0000, 17'd0, 32'h0001_0000, 1'b1);
    // zero threshold
    write_reg(rtp_pkg::REG_ALPHA, 32'd0);
    send_item(32'h0002_0000, 17'd30000, 32'h0010_0000, 1'b0);
    send_item(32'h0003_0000, 17'd30000, 32'h0010_0000, 1'b1);
    // too many items, dropped last item still starts the run
    write_reg(rtp_pkg::REG_ALPHA, rtp_pkg::ALPHA_RESET);
    for (int k = 0; k < 18; k++)
      send_item(32'($urandom_range(0, 32'h0008_0000)), pick_prob(), 32'h0020_0000, k == 17);

    // long result stall while the sender keeps offering
    wait_drained();
    hold_left = 6000;
    send_set(16);
    send_set(3);

    // random phases, one stretch without idling
    for (int phase = 0; items_sent < 200; phase++) begin
      idle_pct = (phase == 3) ? 0 : 32;
      case ($urandom_range(0, 4))
        0: write_reg(rtp_pkg::REG_ALPHA, 32'd0);
        1: write_reg(rtp_pkg::REG_ALPHA, 32'hffff_ffff);
        2: write_reg(rtp_pkg::REG_ALPHA, rtp_pkg::ALPHA_RESET);
        3: write_reg(rtp_pkg::REG_ALPHA, $urandom_range(0, 32'h0010_0000));
        default: write_reg(rtp_pkg::REG_ALPHA, $urandom);
      endcase
      write_reg(rtp_pkg::REG_FIRST, 32'($urandom_range(0, 1)));
      for (int s = 0; s < 6; s++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 6);
        send_set(n);
      end
    end
    idle_pct = 32;

    wait_drained();
    $display("sets %0d, items %0d, results %0d, sets with a root %0d, overflow sets %0d",
             sb.sets_done, items_sent, sb.results_seen, sb.rooted_sets, sb.overflow_sets);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
